// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/msct_pkg.sv =====
// Types, widths and codes for the mean and deviation color transfer block.
`timescale 1ns / 1ps
`default_nettype none
package msct_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int FRAC_BITS  = 16;
   localparam int PIX_W      = 8;
   localparam int NUM_CHAN   = 3;
   localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
   localparam int ADDR_W     = $clog2(MAX_PIXELS);
   localparam int SUM_W      = PIX_W + ADDR_W;
   localparam int SQ_W       = 2 * PIX_W + ADDR_W;
   localparam int NSQ_W      = CNT_W + SQ_W;
   localparam int N2_W       = 2 * CNT_W;
   // population variance stays below 2^(2*PIX_W-2)
   localparam int VAR_W      = 2 * (PIX_W - 1) + 2 * FRAC_BITS;
   localparam int STD_W      = VAR_W / 2;
   localparam int Q_W        = PIX_W + FRAC_BITS;
   localparam int DIV_W      = NSQ_W + 2 * FRAC_BITS;
   localparam int DEN_W      = N2_W;
   localparam int V_W        = Q_W + 2;
   localparam int X_W        = PIX_W + 2;
   localparam int P_W        = X_W + Q_W + 1;

   localparam logic [1:0]     LAST_CHAN = 2'(NUM_CHAN - 1);
   localparam logic [Q_W-1:0] GAIN_MAX  = '1;

   typedef enum logic [1:0] {
      OP_LOAD_SRC = 2'd0,
      OP_LOAD_TGT = 2'd1,
      OP_READ     = 2'd2,
      OP_NEW_JOB  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_DIFF, ST_VGO, ST_VWAIT, ST_SWAIT, ST_MWAIT,
      ST_GGO, ST_GWAIT, ST_MEMRD, ST_CV1, ST_CV2, ST_CV3
   } state_type;

   typedef struct packed {
      logic       load_src;
      logic       load_tgt;
      logic       new_job;
      logic       fault_rsp;
      logic       mul;
      logic       diff;
      logic       vdiv_start;
      logic       sqrt_start;
      logic       std_store;
      logic       mdiv_start;
      logic       mean_store;
      logic       gdiv_start;
      logic       gain_store;
      logic       stats_set;
      logic       mem_rd;
      logic       cv1;
      logic       cv2;
      logic       cv3;
      logic       img;
      logic [1:0] chan;
   } dp_cmd_type;

   typedef struct packed {
      logic fault_cond;
      logic stats_ready;
      logic div_done;
      logic sqrt_done;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/msct_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module msct_div import msct_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);
   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_s;
   logic             fits;

   always_comb begin
      rem_s   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = rem_s >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? DEN_W'(rem_s - {1'b0, den_ff}) : rem_s[DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) den_ff <= divisor;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/msct_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module msct_sqrt import msct_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [VAR_W-1:0] radicand,
   output logic                  done,
   output logic [STD_W-1:0]      root
);
   localparam int REM_W = STD_W + 2;
   localparam int CW    = $clog2(STD_W);

   logic [VAR_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [STD_W-1:0] root_ff, root_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] rem_s, trial;
   logic             fits;

   always_comb begin
      rem_s   = {rem_ff[REM_W-3:0], rad_ff[VAR_W-1:VAR_W-2]};
      trial   = {root_ff, 2'b01};
      fits    = rem_s >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[VAR_W-3:0], 2'b00};
         rem_in  = fits ? rem_s - trial : rem_s;
         root_in = {root_ff[STD_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// ===== rtl/msct_datapath.sv =====
// Accumulators, target store, statistics units and pixel conversion.
`timescale 1ns / 1ps
`default_nettype none
module msct_datapath import msct_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dp_cmd_type       cmd,
   input  wire logic [PIX_W-1:0] chan_a,
   input  wire logic [PIX_W-1:0] chan_b,
   input  wire logic [PIX_W-1:0] chan_c,
   output dp_status_type         status,
   output logic [PIX_W-1:0]      out_a,
   output logic [PIX_W-1:0]      out_b,
   output logic [PIX_W-1:0]      out_c,
   output logic                  run_end,
   output logic                  fault
);
   logic [PIX_W-1:0] pix [NUM_CHAN];

   logic [SUM_W-1:0] src_sum_ff [NUM_CHAN];
   logic [SUM_W-1:0] tgt_sum_ff [NUM_CHAN];
   logic [SQ_W-1:0]  src_sq_ff  [NUM_CHAN];
   logic [SQ_W-1:0]  tgt_sq_ff  [NUM_CHAN];
   logic [CNT_W-1:0] src_cnt_ff, tgt_cnt_ff, rd_pos_ff;
   logic             stats_ready_ff, overflow_ff;

   logic [Q_W-1:0]   src_mean_ff [NUM_CHAN];
   logic [Q_W-1:0]   tgt_mean_ff [NUM_CHAN];
   logic [Q_W-1:0]   gain_ff     [NUM_CHAN];
   logic [STD_W-1:0] src_std_ff  [NUM_CHAN];
   logic [STD_W-1:0] tgt_std_ff  [NUM_CHAN];

   logic [NSQ_W-1:0] a_ff, d_ff;
   logic [2*SUM_W-1:0] b_ff;
   logic [N2_W-1:0]  n2_ff;

   logic [3*PIX_W-1:0] store_mem [MAX_PIXELS];
   logic [3*PIX_W-1:0] rd_data_ff;

   logic signed [X_W-1:0] x_ff    [NUM_CHAN];
   logic signed [P_W-1:0] prod_ff [NUM_CHAN];
   logic [PIX_W-1:0]      res_in  [NUM_CHAN];
   logic signed [X_W-1:0] x_in    [NUM_CHAN];
   logic signed [P_W-1:0] prod_in [NUM_CHAN];

   logic [PIX_W-1:0] out_ff [NUM_CHAN];
   logic             run_end_ff, fault_ff;

   logic [CNT_W-1:0] sel_n;
   logic [SUM_W-1:0] sel_sum;
   logic [SQ_W-1:0]  sel_sq;
   logic             div_start, div_done, sqrt_done;
   logic [DIV_W-1:0] div_num, div_q;
   logic [DEN_W-1:0] div_den;
   logic [STD_W-1:0] sqrt_root;
   logic [CNT_W-1:0] rd_next;

   assign pix[0] = chan_a;
   assign pix[1] = chan_b;
   assign pix[2] = chan_c;

   assign sel_n   = cmd.img ? tgt_cnt_ff : src_cnt_ff;
   assign sel_sum = cmd.img ? tgt_sum_ff[cmd.chan] : src_sum_ff[cmd.chan];
   assign sel_sq  = cmd.img ? tgt_sq_ff[cmd.chan] : src_sq_ff[cmd.chan];
   assign rd_next = rd_pos_ff + 1'b1;

   // accumulate, count and flag
   always_ff @(posedge clock) begin
      if (reset || cmd.new_job) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            src_sum_ff[k] <= '0;
            tgt_sum_ff[k] <= '0;
            src_sq_ff[k]  <= '0;
            tgt_sq_ff[k]  <= '0;
         end
         src_cnt_ff     <= '0;
         tgt_cnt_ff     <= '0;
         rd_pos_ff      <= '0;
         stats_ready_ff <= 1'b0;
         overflow_ff    <= 1'b0;
      end else begin
         if (cmd.load_src || cmd.load_tgt) stats_ready_ff <= 1'b0;
         if (cmd.stats_set) stats_ready_ff <= 1'b1;
         if (cmd.load_src) begin
            if (src_cnt_ff == CNT_W'(MAX_PIXELS)) begin
               overflow_ff <= 1'b1;
            end else begin
               for (int k = 0; k < NUM_CHAN; k++) begin
                  src_sum_ff[k] <= src_sum_ff[k] + SUM_W'(pix[k]);
                  src_sq_ff[k]  <= src_sq_ff[k] + SQ_W'(pix[k] * pix[k]);
               end
               src_cnt_ff <= src_cnt_ff + 1'b1;
            end
         end
         if (cmd.load_tgt) begin
            if (tgt_cnt_ff == CNT_W'(MAX_PIXELS)) begin
               overflow_ff <= 1'b1;
            end else begin
               for (int k = 0; k < NUM_CHAN; k++) begin
                  tgt_sum_ff[k] <= tgt_sum_ff[k] + SUM_W'(pix[k]);
                  tgt_sq_ff[k]  <= tgt_sq_ff[k] + SQ_W'(pix[k] * pix[k]);
               end
               tgt_cnt_ff <= tgt_cnt_ff + 1'b1;
            end
         end
         if (cmd.cv3) rd_pos_ff <= rd_next;
      end
   end

   // target store
   always_ff @(posedge clock) begin
      if (cmd.load_tgt && tgt_cnt_ff != CNT_W'(MAX_PIXELS))
         store_mem[tgt_cnt_ff[ADDR_W-1:0]] <= {chan_c, chan_b, chan_a};
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rd_data_ff <= store_mem[rd_pos_ff[ADDR_W-1:0]];
   end

   // variance numerator: n*sumsq - sum^2
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         a_ff  <= NSQ_W'(sel_n * sel_sq);
         b_ff  <= sel_sum * sel_sum;
         n2_ff <= sel_n * sel_n;
      end
      if (cmd.diff) d_ff <= (a_ff > NSQ_W'(b_ff)) ? a_ff - NSQ_W'(b_ff) : '0;
   end

   assign div_start = cmd.vdiv_start || cmd.mdiv_start || cmd.gdiv_start;

   // a zero source deviation divides by zero: all-ones quotient saturates the gain
   always_comb begin
      priority if (cmd.vdiv_start) begin
         div_num = {d_ff, (2 * FRAC_BITS)'(0)};
         div_den = n2_ff;
      end else if (cmd.mdiv_start) begin
         div_num = DIV_W'({sel_sum, FRAC_BITS'(0)});
         div_den = DEN_W'(sel_n);
      end else begin
         div_num = DIV_W'({tgt_std_ff[cmd.chan], FRAC_BITS'(0)});
         div_den = DEN_W'(src_std_ff[cmd.chan]);
      end
   end

   msct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   msct_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (div_q[VAR_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (cmd.std_store) begin
         if (cmd.img) tgt_std_ff[cmd.chan] <= sqrt_root;
         else         src_std_ff[cmd.chan] <= sqrt_root;
      end
      if (cmd.mean_store) begin
         if (cmd.img) tgt_mean_ff[cmd.chan] <= div_q[Q_W-1:0];
         else         src_mean_ff[cmd.chan] <= div_q[Q_W-1:0];
      end
      if (cmd.gain_store)
         gain_ff[cmd.chan] <= (div_q > DIV_W'(GAIN_MAX)) ? GAIN_MAX : div_q[Q_W-1:0];
   end

   // conversion, truncating toward zero at each step
   always_comb begin
      logic signed [V_W-1:0] v;
      logic [V_W-1:0]        vmag;
      logic [P_W-1:0]        pmag;
      logic signed [P_W-1:0] x2, y;
      for (int k = 0; k < NUM_CHAN; k++) begin
         v     = $signed({2'b00, rd_data_ff[k*PIX_W +: PIX_W], FRAC_BITS'(0)})
                 - $signed({2'b00, tgt_mean_ff[k]});
         vmag  = v[V_W-1] ? -v : v;
         x_in[k] = v[V_W-1] ? -$signed(X_W'(vmag >> FRAC_BITS))
                            : $signed(X_W'(vmag >> FRAC_BITS));
         prod_in[k] = x_ff[k] * $signed({1'b0, gain_ff[k]});
         pmag  = prod_ff[k][P_W-1] ? -prod_ff[k] : prod_ff[k];
         x2    = prod_ff[k][P_W-1] ? -$signed(pmag >> FRAC_BITS) : $signed(pmag >> FRAC_BITS);
         y     = (x2 <<< FRAC_BITS) + $signed(P_W'(src_mean_ff[k]));
         if (y > $signed(P_W'(255) <<< FRAC_BITS)) res_in[k] = '1;
         else if (y < 0)                           res_in[k] = '0;
         else                                      res_in[k] = y[FRAC_BITS +: PIX_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         if (cmd.cv1) x_ff[k] <= x_in[k];
         if (cmd.cv2) prod_ff[k] <= prod_in[k];
         if (cmd.cv3) out_ff[k] <= res_in[k];
         else if (cmd.fault_rsp) out_ff[k] <= '0;
      end
      if (cmd.cv3) begin
         run_end_ff <= (rd_next == tgt_cnt_ff);
         fault_ff   <= 1'b0;
      end else if (cmd.fault_rsp) begin
         run_end_ff <= 1'b0;
         fault_ff   <= 1'b1;
      end
   end

   assign status.fault_cond  = overflow_ff || src_cnt_ff == '0 || tgt_cnt_ff == '0
                               || rd_pos_ff >= tgt_cnt_ff;
   assign status.stats_ready = stats_ready_ff;
   assign status.div_done    = div_done;
   assign status.sqrt_done   = sqrt_done;

   assign out_a   = out_ff[0];
   assign out_b   = out_ff[1];
   assign out_c   = out_ff[2];
   assign run_end = run_end_ff;
   assign fault   = fault_ff;
endmodule
`default_nettype wire

// ===== rtl/msct_ctrl.sv =====
// Controller: handshakes, statistics sequencing and read pipeline.
`timescale 1ns / 1ps
`default_nettype none
module msct_ctrl import msct_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_op,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);
   state_type  state_ff, state_in;
   logic       img_ff, img_in;
   logic [1:0] chan_ff, chan_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_acc;
   op_type     op;

   assign op        = op_type'(req_op);
   // a read waits while an earlier word sits stalled at the output
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall && op == OP_READ);
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      img_in   = img_ff;
      chan_in  = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && op == OP_READ && !status.fault_cond) begin
               if (status.stats_ready) begin
                  state_in = ST_MEMRD;
               end else begin
                  state_in = ST_MUL;
                  img_in   = 1'b0;
                  chan_in  = '0;
               end
            end
         end
         ST_MUL:   state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_VGO;
         ST_VGO:   state_in = ST_VWAIT;
         ST_VWAIT: if (status.div_done) state_in = ST_SWAIT;
         ST_SWAIT: if (status.sqrt_done) state_in = ST_MWAIT;
         ST_MWAIT: begin
            if (status.div_done) begin
               if (img_ff && chan_ff == LAST_CHAN) begin
                  state_in = ST_GGO;
                  chan_in  = '0;
               end else begin
                  state_in = ST_MUL;
                  img_in   = !img_ff;
                  if (img_ff) chan_in = chan_ff + 1'b1;
               end
            end
         end
         ST_GGO:   state_in = ST_GWAIT;
         ST_GWAIT: begin
            if (status.div_done) begin
               if (chan_ff == LAST_CHAN) begin
                  state_in = ST_MEMRD;
               end else begin
                  state_in = ST_GGO;
                  chan_in  = chan_ff + 1'b1;
               end
            end
         end
         ST_MEMRD: state_in = ST_CV1;
         ST_CV1:   state_in = ST_CV2;
         ST_CV2:   state_in = ST_CV3;
         ST_CV3:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.img  = img_ff;
      cmd.chan = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (op)
                  OP_LOAD_SRC: cmd.load_src  = 1'b1;
                  OP_LOAD_TGT: cmd.load_tgt  = 1'b1;
                  OP_NEW_JOB:  cmd.new_job   = 1'b1;
                  OP_READ:     cmd.fault_rsp = status.fault_cond;
                  default:     cmd.new_job   = 1'b0;
               endcase
            end
         end
         ST_MUL:   cmd.mul        = 1'b1;
         ST_DIFF:  cmd.diff       = 1'b1;
         ST_VGO:   cmd.vdiv_start = 1'b1;
         ST_VWAIT: cmd.sqrt_start = status.div_done;
         ST_SWAIT: begin
            cmd.std_store  = status.sqrt_done;
            cmd.mdiv_start = status.sqrt_done;
         end
         ST_MWAIT: cmd.mean_store = status.div_done;
         ST_GGO:   cmd.gdiv_start = 1'b1;
         ST_GWAIT: begin
            cmd.gain_store = status.div_done;
            cmd.stats_set  = status.div_done && chan_ff == LAST_CHAN;
         end
         ST_MEMRD: cmd.mem_rd = 1'b1;
         ST_CV1:   cmd.cv1    = 1'b1;
         ST_CV2:   cmd.cv2    = 1'b1;
         ST_CV3:   cmd.cv3    = 1'b1;
         default:  cmd.mem_rd = 1'b0;
      endcase
   end

   always_comb begin
      priority if (cmd.fault_rsp || cmd.cv3) rsp_valid_in = 1'b1;
      else if (!rsp_stall)                   rsp_valid_in = 1'b0;
      else                                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         img_ff       <= 1'b0;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         img_ff       <= img_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== rtl/mean_std_color_transfer.sv =====
// Top level of the mean and deviation color transfer block.
// Request channel (req_*): one word per operation. op 0 loads a source pixel,
// op 1 loads a target pixel into the store, op 3 starts a new job; these give
// no response. op 2 asks for the next converted target pixel and always gives
// exactly one response word on rsp_*.
// A read with current statistics steps through ST_MEMRD, ST_CV1, ST_CV2 and
// ST_CV3, and its response word is registered. The first read after any load
// first recomputes the statistics: six variance/mean passes and three gain
// divisions on one shared 81-step divider plus a 23-step root unit. One request
// is worked at a time; req_stall is high throughout. A faulting read (overflow,
// empty image, nothing left) answers with fault set and all other fields zero.
// Loads and new-job words are still taken while a response waits; a read is
// held off while an earlier response is stalled by rsp_stall, and a stalled
// response word holds its value.
// Reset clears counts, sums and flags; the target store content is undefined
// until written. req_final_pixel is taken but has no effect.
`timescale 1ns / 1ps
`default_nettype none
module mean_std_color_transfer import msct_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_op,
   input  wire logic [PIX_W-1:0] req_chan_a,
   input  wire logic [PIX_W-1:0] req_chan_b,
   input  wire logic [PIX_W-1:0] req_chan_c,
   input  wire logic             req_final_pixel,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [PIX_W-1:0]      rsp_out_a,
   output logic [PIX_W-1:0]      rsp_out_b,
   output logic [PIX_W-1:0]      rsp_out_c,
   output logic                  rsp_run_end,
   output logic                  rsp_fault
);
   dp_cmd_type    cmd;
   dp_status_type status;

   msct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msct_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .chan_a  (req_chan_a),
      .chan_b  (req_chan_b),
      .chan_c  (req_chan_c),
      .status  (status),
      .out_a   (rsp_out_a),
      .out_b   (rsp_out_b),
      .out_c   (rsp_out_c),
      .run_end (rsp_run_end),
      .fault   (rsp_fault)
   );
endmodule
`default_nettype wire

// ===== rtl/msct_checker.sv =====
// Port-level checks for the color transfer block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module msct_checker import msct_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_op,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_a,
   input wire logic [7:0] rsp_out_b,
   input wire logic [7:0] rsp_out_c,
   input wire logic       rsp_run_end,
   input wire logic       rsp_fault
);
   `ASSERT_IMPL(fault_word_zero, clock, reset, rsp_valid && rsp_fault,
      rsp_out_a == 8'd0 && rsp_out_b == 8'd0 && rsp_out_c == 8'd0 && !rsp_run_end)
   `ASSERT_IMPL(end_not_fault, clock, reset, rsp_valid, !(rsp_run_end && rsp_fault))
   `ASSERT_NEXT(load_no_word, clock, reset,
      req_valid && !req_stall && req_op != OP_READ && !rsp_valid, !rsp_valid)
   `ASSERT_NEXT(stalled_word_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_a) && $stable(rsp_fault) && $stable(rsp_run_end))
endmodule

bind mean_std_color_transfer msct_checker u_checker (.*);
`default_nettype wire

// ===== tb/mean_std_color_transfer_tb.sv =====
// Testbench for the mean and deviation color transfer block: directed and random jobs.
`timescale 1ns / 1ps
`default_nettype none
module mean_std_color_transfer_tb;
   import msct_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int NUM_WORDS  = 1100;

   // Golden model of the color transfer and the queue of expected pixels.
   class transfer_scoreboard;
      bit [23:0]   tgt_pix[$];
      longint unsigned src_sum[3], src_sq[3], tgt_sum[3], tgt_sq[3];
      longint unsigned src_cnt, tgt_cnt, rd_pos;
      longint unsigned src_mean[3], tgt_mean[3], gain[3];
      bit          ready, ovf;
      bit [25:0]   expect_q[$];   // {c, b, a, run_end, fault}
      int          errors;
      int          checked;

      function void clear_job();
         for (int k = 0; k < 3; k++) begin
            src_sum[k] = 0; src_sq[k] = 0; tgt_sum[k] = 0; tgt_sq[k] = 0;
         end
         src_cnt = 0; tgt_cnt = 0; rd_pos = 0; ready = 0; ovf = 0;
         tgt_pix.delete();
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint unsigned deviation(longint unsigned n, longint unsigned s,
                                          longint unsigned sq);
         longint unsigned a, b, d, n2, q, r;
         a = n * sq;
         b = s * s;
         if (a <= b) return 0;
         d = a - b;
         n2 = n * n;
         q = d / n2;
         r = d % n2;
         for (int i = 0; i < 2 * FRAC_BITS; i++) begin
            r <<= 1; q <<= 1;
            if (r >= n2) begin
               r -= n2; q |= 1;
            end
         end
         return root(q);
      endfunction

      function void update_stats();
         longint unsigned gmax, ss, ts, g;
         gmax = (64'd1 << (8 + FRAC_BITS)) - 1;
         for (int k = 0; k < 3; k++) begin
            ss = deviation(src_cnt, src_sum[k], src_sq[k]);
            ts = deviation(tgt_cnt, tgt_sum[k], tgt_sq[k]);
            src_mean[k] = (src_sum[k] << FRAC_BITS) / src_cnt;
            tgt_mean[k] = (tgt_sum[k] << FRAC_BITS) / tgt_cnt;
            if (ss == 0) gain[k] = gmax;
            else begin
               g = (ts << FRAC_BITS) / ss;
               gain[k] = g > gmax ? gmax : g;
            end
         end
         ready = 1;
      endfunction

      function longint drop_frac(longint v);
         if (v < 0) return -longint'(longint'(-v) >>> FRAC_BITS);
         return v >>> FRAC_BITS;
      endfunction

      function bit [7:0] convert_chan(bit [7:0] p, int k);
         longint x, y;
         x = drop_frac((longint'(p) <<< FRAC_BITS) - longint'(tgt_mean[k]));
         x = drop_frac(x * longint'(gain[k]));
         y = (x <<< FRAC_BITS) + longint'(src_mean[k]);
         if (y > (longint'(255) <<< FRAC_BITS)) return 8'd255;
         if (y < 0) return 8'd0;
         return 8'(y >>> FRAC_BITS);
      endfunction

      function void note_request(op_type op, bit [7:0] a, bit [7:0] b, bit [7:0] c);
         bit [7:0] ch[3];
         bit [23:0] px;
         ch[0] = a; ch[1] = b; ch[2] = c;
         case (op)
            OP_LOAD_SRC, OP_LOAD_TGT: begin
               ready = 0;
               if ((op == OP_LOAD_SRC ? src_cnt : tgt_cnt) >= MAX_PIXELS) begin
                  ovf = 1;
                  return;
               end
               for (int k = 0; k < 3; k++) begin
                  if (op == OP_LOAD_SRC) begin
                     src_sum[k] += ch[k]; src_sq[k] += ch[k] * ch[k];
                  end else begin
                     tgt_sum[k] += ch[k]; tgt_sq[k] += ch[k] * ch[k];
                  end
               end
               if (op == OP_LOAD_SRC) src_cnt++;
               else begin
                  tgt_pix.push_back({c, b, a});
                  tgt_cnt++;
               end
            end
            OP_NEW_JOB: clear_job();
            default: begin
               if (ovf || src_cnt == 0 || tgt_cnt == 0 || rd_pos >= tgt_cnt) begin
                  expect_q.push_back({24'd0, 1'b0, 1'b1});
               end else begin
                  if (!ready) update_stats();
                  px = tgt_pix[rd_pos];
                  rd_pos++;
                  expect_q.push_back({convert_chan(px[23:16], 2), convert_chan(px[15:8], 1),
                                      convert_chan(px[7:0], 0), rd_pos == tgt_cnt, 1'b0});
               end
            end
         endcase
      endfunction

      function void check_result(bit [7:0] a, bit [7:0] b, bit [7:0] c, bit re, bit f);
         bit [25:0] e;
         if (expect_q.size() == 0) begin
            $error("unexpected response word");
            errors++;
            return;
         end
         e = expect_q.pop_front();
         checked++;
         if (e[9:2] != a) begin
            $error("out_a expected %0d got %0d", e[9:2], a); errors++;
         end
         if (e[17:10] != b) begin
            $error("out_b expected %0d got %0d", e[17:10], b); errors++;
         end
         if (e[25:18] != c) begin
            $error("out_c expected %0d got %0d", e[25:18], c); errors++;
         end
         if (e[1] != re) begin
            $error("run_end expected %0d got %0d", e[1], re); errors++;
         end
         if (e[0] != f) begin
            $error("fault expected %0d got %0d", e[0], f); errors++;
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_stall, req_final_pixel;
   logic [1:0] req_op;
   logic [7:0] req_chan_a, req_chan_b, req_chan_c;
   logic       rsp_valid, rsp_stall;
   logic [7:0] rsp_out_a, rsp_out_b, rsp_out_c;
   logic       rsp_run_end, rsp_fault;

   transfer_scoreboard board;
   int  idle_cycles;
   int  reads_sent;
   int  words_sent;

   mean_std_color_transfer dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one word and hold it until taken; valid stays up for a back-to-back word.
   task automatic send_word(op_type op, bit [7:0] a, bit [7:0] b, bit [7:0] c, bit fin,
                            bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1; req_op <= op;
      req_chan_a <= a; req_chan_b <= b; req_chan_c <= c; req_final_pixel <= fin;
      do @(posedge clock); while (req_stall);
      board.note_request(op, a, b, c);
      words_sent++;
      if (op == OP_READ) reads_sent++;
   endtask

   task automatic send_job(int ns, int nt, int nr, int style, bit gaps);
      bit [7:0] a, b, c;
      send_word(OP_NEW_JOB, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), gaps);
      for (int i = 0; i < ns + nt; i++) begin
         case (style)
            0: begin a = 8'($urandom); b = 8'($urandom); c = 8'($urandom); end
            1: begin a = 8'd77; b = 8'd0; c = 8'd255; end
            default: begin
               a = 8'($urandom_range(100, 140)); b = 8'($urandom_range(0, 20));
               c = 8'($urandom_range(200, 255));
            end
         endcase
         send_word(i < ns ? OP_LOAD_SRC : OP_LOAD_TGT, a, b, c,
                   (i == ns - 1) || (i == ns + nt - 1), gaps);
      end
      for (int i = 0; i < nr; i++)
         send_word(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), gaps);
   endtask

   // Response side: stall at random and check each word as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_out_a, rsp_out_b, rsp_out_c, rsp_run_end, rsp_fault);
         rsp_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 9) != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      board = new();
      board.clear_job();
      reset = 1; req_valid = 0; req_op = OP_NEW_JOB;
      req_chan_a = 0; req_chan_b = 0; req_chan_c = 0; req_final_pixel = 0;
      reads_sent = 0; words_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty images, extremes, flat source, run past the end.
      send_word(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 0);
      send_word(OP_LOAD_SRC, 8'd255, 8'd0, 8'd255, 1'b0, 0);
      send_word(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 0);
      send_word(OP_LOAD_SRC, 8'd0, 8'd255, 8'd128, 1'b1, 0);
      send_word(OP_LOAD_TGT, 8'd0, 8'd0, 8'd0, 1'b0, 0);
      send_word(OP_LOAD_TGT, 8'd255, 8'd255, 8'd255, 1'b1, 0);
      send_word(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 0);
      // load after read forces new statistics; read position is kept
      send_word(OP_LOAD_TGT, 8'd10, 8'd200, 8'd90, 1'b1, 0);
      repeat (3) send_word(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 0);
      send_job(3, 2, 3, 1, 0);
      send_job(1, 1, 1, 0, 0);

      // Random jobs, mostly well formed.
      while (words_sent < NUM_WORDS) begin
         case ($urandom_range(0, 9))
            0: send_word(op_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom), 1);
            1: send_job($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 9),
                        $urandom_range(0, 2), 1);
            default: send_job($urandom_range(1, 12), $urandom_range(1, 12),
                              $urandom_range(1, 12), $urandom_range(0, 2), 1);
         endcase
      end
      req_valid <= 0;
      while (board.expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d words with %0d reads, %0d responses checked", words_sent,
               reads_sent, board.checked);
      $display("jobs mixed random, flat and narrow-range images with stalls on both sides");
      if (board.errors == 0 && board.expect_q.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
